FILE: hw/rtl/sdlr_pkg.sv
// shared constants for the shuffled dual congruential random source
`timescale 1ns / 1ps
`default_nettype none

package sdlr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned VAL_W           = 31;

  localparam logic [30:0] MOD_ONE      = 31'd2147483563;
  localparam logic [30:0] MOD_TWO      = 31'd2147483399;
  localparam logic [30:0] MOD_ONE_LESS = 31'd2147483562;
  localparam logic [15:0] MUL_ONE      = 16'd40014;
  localparam logic [15:0] MUL_TWO      = 16'd40692;
  localparam logic [15:0] QUO_ONE      = 16'd53668;
  localparam logic [15:0] QUO_TWO      = 16'd52774;
  localparam logic [15:0] REM_ONE      = 16'd12211;
  localparam logic [15:0] REM_TWO      = 16'd3791;
  localparam logic [30:0] GEN_TWO_RST  = 31'd123456789;

  // floor(2^31 / quotient) for the reciprocal estimate of v / quotient
  localparam logic [15:0] RECIP_ONE = 16'd40014;
  localparam logic [15:0] RECIP_TWO = 16'd40692;

  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/sdlr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sdlr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/shuffled_dual_lcg_random.sv
// top level of the shuffled dual congruential random source
//
// input stream (s_*): one transaction asks for a draw (s_tuser = 0) or a
// reseed followed by a draw (s_tuser = 1, seed in s_tdata); exactly one
// result transaction (m_*) comes out for every input transaction
// all multiplications run through a single 31x16 multiplier under a small
// sequencer: each generator step (schrage) runs through S_K, S_KQ, S_KC,
// S_MA, S_MB and S_FIN, the table index divide through S_JA, S_JB and S_JC,
// the table read-modify-write through S_JC and S_RD; a draw steps both
// generators, then runs the index and table states, and ends in S_PUSH
// a reseed adds TABLE_DEPTH + 8 warm-up steps of the first generator that
// refill the shuffle table before the draw
// s_tready is high only while the sequencer is idle
// the result sits in an output register, so a new item is taken while an
// earlier result still waits; if the receiver stalls for longer, the next
// result is held in the sequencer until the register frees
// reset (rst, synchronous) sets gen_one to 1, gen_two to 123456789, the mix
// value to 0 and marks every table entry as zero through its valid bit
// the consumer forms the uniform float as value / 2147483563
`timescale 1ns / 1ps
`default_nettype none

module shuffled_dual_lcg_random #(
  parameter int unsigned TABLE_DEPTH = sdlr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,  // [30:0] seed, [31] zero fill
  input  wire logic        s_tuser,  // [0] func: 0 draw, 1 reseed then draw
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata   // [30:0] value, [31] zero fill
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);

  // index divisor and its reciprocal, worked out at elaboration
  localparam longint unsigned NDIV_L  = 64'd1 + (64'd2147483562 / 64'(TABLE_DEPTH));
  localparam longint unsigned RD_L    = 64'h8000_0000 / NDIV_L;
  localparam logic [30:0]     NDIV    = NDIV_L[30:0];
  localparam logic [15:0]     RD      = RD_L[15:0];
  localparam logic [15:0]     J_MAX   = 16'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0]   WARM_N  = CW'(TABLE_DEPTH + 7);
  localparam logic [CW-1:0]   DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_K    = 12'h002,  // v * reciprocal
    S_KQ   = 12'h004,  // k estimate * quotient
    S_KC   = 12'h008,  // correct k, remainder
    S_MA   = 12'h010,  // multiplier * remainder
    S_MB   = 12'h020,  // k * rem
    S_FIN  = 12'h040,  // generator result
    S_JA   = 12'h080,  // mix * index reciprocal
    S_JB   = 12'h100,  // index estimate * divisor
    S_JC   = 12'h200,  // correct index, table read
    S_RD   = 12'h400,  // new mix value, table write
    S_PUSH = 12'h800   // hand to output register
  } state_t;

  state_t state, state_next;

  logic [30:0]   gen_one, gen_two, mix;
  logic          gsel;      // 0 steps gen_one, 1 steps gen_two
  logic          warm;      // reseed warm-up in progress
  logic [CW-1:0] cnt;
  logic [46:0]   prod;
  logic [15:0]   k;
  logic [15:0]   r;
  logic [31:0]   a_reg;
  logic [15:0]   jq;
  logic [AW-1:0] j_reg;
  logic          rd_valid;
  logic [TABLE_DEPTH-1:0] valid;

  // shared multiplier
  logic [30:0] mul_a;
  logic [15:0] mul_b;
  logic [46:0] mul_p;

  // per-generator constants
  logic [30:0] v_op, mod_op;
  logic [15:0] recip_op, quo_op, mulc_op, rem_op;

  always_comb begin
    v_op     = gsel ? gen_two           : gen_one;
    mod_op   = gsel ? sdlr_pkg::MOD_TWO : sdlr_pkg::MOD_ONE;
    recip_op = gsel ? sdlr_pkg::RECIP_TWO : sdlr_pkg::RECIP_ONE;
    quo_op   = gsel ? sdlr_pkg::QUO_TWO : sdlr_pkg::QUO_ONE;
    mulc_op  = gsel ? sdlr_pkg::MUL_TWO : sdlr_pkg::MUL_ONE;
    rem_op   = gsel ? sdlr_pkg::REM_TWO : sdlr_pkg::REM_ONE;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_K:  begin mul_a = v_op;              mul_b = recip_op;     end
      S_KQ: begin mul_a = {15'd0, prod[46:31]}; mul_b = quo_op;    end
      S_MA: begin mul_a = {15'd0, r};        mul_b = mulc_op;      end
      S_MB: begin mul_a = {15'd0, k};        mul_b = rem_op;       end
      S_JA: begin mul_a = mix;               mul_b = RD;           end
      S_JB: begin mul_a = NDIV;              mul_b = prod[46:31];  end
      default: begin mul_a = '0;             mul_b = '0;           end
    endcase
  end

  assign mul_p = {16'd0, mul_a} * {31'd0, mul_b};

  // remainder correction of the k estimate
  logic [30:0] r_est;
  logic        r_over;
  assign r_est  = v_op - prod[30:0];
  assign r_over = (r_est >= {15'd0, quo_op});

  // generator result: a - b, folded back into range when negative
  logic [32:0] fin_diff, fin_n;
  assign fin_diff = {1'b0, a_reg} - {1'b0, prod[31:0]};
  assign fin_n    = fin_diff[32] ? (fin_diff + {2'd0, mod_op}) : fin_diff;

  // table index correction and clamp
  logic [30:0]   j_rem;
  logic [15:0]   j_full;
  logic [AW-1:0] j_idx;
  assign j_rem  = mix - prod[30:0];
  assign j_full = (j_rem >= NDIV) ? (jq + 16'd1) : jq;
  assign j_idx  = (j_full > J_MAX) ? J_MAX[AW-1:0] : j_full[AW-1:0];

  // new mix value from the shuffle table entry
  logic [30:0] rdata, tab;
  logic [32:0] mix_diff, mix_new;
  assign tab      = rd_valid ? rdata : '0;
  assign mix_diff = {2'd0, tab} - {2'd0, gen_two};
  assign mix_new  = (mix_diff[32] || mix_diff == 33'd0)
                    ? (mix_diff + {2'd0, sdlr_pkg::MOD_ONE_LESS}) : mix_diff;

  // table ram port control
  logic          warm_wr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [30:0]   ram_wdata;
  assign warm_wr   = (state == S_FIN) && !gsel && warm && (cnt < DEPTH_C);
  assign ram_we    = warm_wr || (state == S_RD);
  assign ram_waddr = (state == S_RD) ? j_reg : cnt[AW-1:0];
  assign ram_wdata = (state == S_RD) ? gen_one : fin_n[30:0];

  sdlr_ram #(
    .WIDTH (sdlr_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_JC),
    .raddr (j_idx),
    .rdata (rdata)
  );

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_K;
      end
      S_K:   state_next = S_KQ;
      S_KQ:  state_next = S_KC;
      S_KC:  state_next = S_MA;
      S_MA:  state_next = S_MB;
      S_MB:  state_next = S_FIN;
      S_FIN: begin
        if (gsel) state_next = S_JA;
        else      state_next = S_K;
      end
      S_JA:  state_next = S_JB;
      S_JB:  state_next = S_JC;
      S_JC:  state_next = S_RD;
      S_RD:  state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gen_one  <= 31'd1;
      gen_two  <= sdlr_pkg::GEN_TWO_RST;
      mix      <= '0;
      valid    <= '0;
      gsel     <= 1'b0;
      warm     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= mul_p;

      // result register: load from the sequencer or empty on a handshake
      if (state == S_PUSH && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, mix};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            gsel <= 1'b0;
            cnt  <= WARM_N;
            if (s_tuser == sdlr_pkg::FUNC_RESEED) begin
              warm    <= 1'b1;
              gen_one <= (s_tdata[30:0] == 31'd0) ? 31'd1 : s_tdata[30:0];
              gen_two <= (s_tdata[30:0] == 31'd0) ? 31'd1 : s_tdata[30:0];
            end else begin
              warm <= 1'b0;
            end
          end
        end
        S_KQ: begin
          k <= prod[46:31];
        end
        S_KC: begin
          if (r_over) begin
            k <= k + 16'd1;
            r <= 16'(r_est - {15'd0, quo_op});
          end else begin
            r <= r_est[15:0];
          end
        end
        S_MB: begin
          a_reg <= prod[31:0];
        end
        S_FIN: begin
          if (gsel) begin
            gen_two <= fin_n[30:0];
          end else begin
            gen_one <= fin_n[30:0];
            if (warm_wr) valid[cnt[AW-1:0]] <= 1'b1;
            if (warm) begin
              // last warm-up step leaves entry 0 as the mix value
              if (cnt == '0) begin
                mix  <= fin_n[30:0];
                warm <= 1'b0;
              end else begin
                cnt <= cnt - CW'(1);
              end
            end else begin
              gsel <= 1'b1;
            end
          end
        end
        S_JB: begin
          jq <= prod[46:31];
        end
        S_JC: begin
          j_reg    <= j_idx;
          rd_valid <= valid[j_idx];
        end
        S_RD: begin
          mix          <= mix_new[30:0];
          valid[j_reg] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // results always fall inside the generator range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:0] != 31'd0 && m_tdata[30:0] <= sdlr_pkg::MOD_ONE_LESS))
    else $error("result out of range");

  // one correction step is enough for the reciprocal estimate of k
  assert property (@(posedge clk) disable iff (rst)
    (state == S_KC) |-> (r_est < ({15'd0, quo_op} << 1)))
    else $error("schrage quotient estimate off by more than one");

  // a folded generator result is never negative
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !fin_n[32])
    else $error("generator step left negative");

  // the warm-up only ever steps the first generator
  assert property (@(posedge clk) disable iff (rst)
    warm |-> !gsel)
    else $error("warm-up selected second generator");

  // an accepted transaction starts the first generator step next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_K && !gsel))
    else $error("accepted transaction did not start a step");

endmodule

`default_nettype wire
